// File: rtl/core/tmde_pkg.sv
// shared types and constants for the trimmed mean block
`default_nettype none

package tmde_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned MEAN_W   = 18;
  localparam int unsigned STATUS_W = 2;

  // register indexes on the write port
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  localparam logic [CFG_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [CFG_W-1:0] RANGE_HIGH_RST = 16'd40960;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } tmde_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [STATUS_W-1:0]      status;
  } tmde_out_t;

endpackage

`default_nettype wire

// File: rtl/core/tmde_accum.sv
// per-set accumulation: running sum, extremes, count and overflow flag
`default_nettype none

module tmde_accum #(
  parameter int unsigned IN_W = 16,
  parameter int unsigned CNTW = 9,
  parameter int unsigned SUMW = 25,
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  xfer_i,
  input  wire tmde_pkg::tmde_in_t                    item_i,
  input  wire logic [tmde_pkg::CFG_W-1:0]            range_low_i,
  input  wire logic [tmde_pkg::CFG_W-1:0]            range_high_i,
  output logic [SUMW-1:0]                            sum_o,
  output logic [tmde_pkg::SAMPLE_W-1:0]              largest_o,
  output logic [tmde_pkg::SAMPLE_W-1:0]              smallest_o,
  output logic [CNTW-1:0]                            count_o,
  output logic [tmde_pkg::STATUS_W-1:0]              status_o
);

  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SAMPLES);

  logic [SUMW-1:0]               sum_q, sum_d;
  logic [tmde_pkg::SAMPLE_W-1:0] lg_q, lg_d, sm_q, sm_d, lg_cur, sm_cur, smp;
  logic [CNTW-1:0]               cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;

  // only the low IN_W sample bits count
  assign smp = tmde_pkg::SAMPLE_W'(item_i.sample[IN_W-1:0]);

  // trackers restart from the registers at the start of a set
  assign lg_cur = (cnt_q == '0) ? range_low_i  : lg_q;
  assign sm_cur = (cnt_q == '0) ? range_high_i : sm_q;

  always_comb begin
    sum_d = sum_q;
    lg_d  = lg_cur;
    sm_d  = sm_cur;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cnt_q >= CNT_MAX) begin
      ovf_d = 1'b1;
    end else begin
      sum_d = sum_q + SUMW'(smp);
      if (smp > lg_cur) lg_d = smp;
      if (smp < sm_cur) sm_d = smp;
      cnt_d = cnt_q + CNTW'(1);
    end
  end

  assign sum_o      = sum_d;
  assign largest_o  = lg_d;
  assign smallest_o = sm_d;
  assign count_o    = cnt_d;

  always_comb begin
    if (ovf_d) begin
      status_o = tmde_pkg::STATUS_OVERFLOW;
    end else if (cnt_d < CNTW'(3)) begin
      status_o = tmde_pkg::STATUS_SHORT;
    end else begin
      status_o = tmde_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (xfer_i) begin
      if (item_i.last) begin
        sum_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_i) begin
      lg_q <= lg_d;
      sm_q <= sm_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tmde_div.sv
// closing sequencer: numerator, shared restoring divider, sign and saturation
`default_nettype none

module tmde_div #(
  parameter int unsigned CNTW = 9,
  parameter int unsigned SUMW = 25,
  parameter int unsigned NUMW = 26
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [SUMW-1:0]                       sum_i,
  input  wire logic [tmde_pkg::SAMPLE_W-1:0]         largest_i,
  input  wire logic [tmde_pkg::SAMPLE_W-1:0]         smallest_i,
  input  wire logic [CNTW-1:0]                       count_i,
  input  wire logic [tmde_pkg::STATUS_W-1:0]         status_i,
  input  wire logic                                  slot_free_i,
  output logic                                       busy_o,
  output logic                                       done_o,
  output tmde_pkg::tmde_out_t                        result_o
);

  localparam int unsigned STW = $clog2(NUMW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_NEG  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  localparam logic [NUMW-1:0] POS_LIM = NUMW'(131071);
  localparam logic [NUMW-1:0] NEG_LIM = NUMW'(131072);

  logic [2:0]                         state_q, state_d;
  logic [SUMW-1:0]                    sum_q;
  logic [tmde_pkg::SAMPLE_W-1:0]      lg_q, sm_q;
  logic [CNTW-1:0]                    den_q, rem_q, rem_d;
  logic [NUMW-1:0]                    dvd_q, dvd_d;
  logic                               neg_q, neg_d;
  logic [STW-1:0]                     step_q, step_d;
  logic signed [tmde_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [tmde_pkg::STATUS_W-1:0]      status_q;
  logic [CNTW:0]                      shifted, diff;

  assign shifted = {rem_q, dvd_q[NUMW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    step_d  = step_q;
    mean_d  = mean_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mean_d  = '0;
          state_d = (status_i == tmde_pkg::STATUS_OK) ? S_SUB : S_HOLD;
        end
      end
      S_SUB: begin
        dvd_d   = NUMW'(sum_q) - NUMW'(lg_q) - NUMW'(sm_q);
        neg_d   = dvd_d[NUMW-1];
        state_d = S_NEG;
      end
      S_NEG: begin
        if (neg_q) dvd_d = -dvd_q;
        rem_d   = '0;
        step_d  = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        // one quotient bit per cycle
        if (!diff[CNTW]) begin
          rem_d = diff[CNTW-1:0];
          dvd_d = {dvd_q[NUMW-2:0], 1'b1};
        end else begin
          rem_d = shifted[CNTW-1:0];
          dvd_d = {dvd_q[NUMW-2:0], 1'b0};
        end
        step_d = step_q + STW'(1);
        if (step_q == STW'(NUMW - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (neg_q) begin
          mean_d = (dvd_q > NEG_LIM) ? -18'sd131072 : -$signed(dvd_q[tmde_pkg::MEAN_W-1:0]);
        end else begin
          mean_d = (dvd_q > POS_LIM) ? 18'sd131071 : $signed(dvd_q[tmde_pkg::MEAN_W-1:0]);
        end
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (slot_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_HOLD) && slot_free_i;
  assign result_o.mean   = mean_q;
  assign result_o.status = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    step_q <= step_d;
    mean_q <= mean_d;
    if (state_q == S_IDLE && start_i) begin
      sum_q    <= sum_i;
      lg_q     <= largest_i;
      sm_q     <= smallest_i;
      den_q    <= count_i - CNTW'(2);
      status_q <= status_i;
    end
  end

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("set closed while divider busy");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> den_q != '0) else $error("zero divisor in divide loop");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && step_q != '0) |-> rem_q < den_q)
    else $error("partial remainder out of range");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q != tmde_pkg::STATUS_OK) |-> mean_q == '0)
    else $error("nonzero mean on flagged set");

endmodule

`default_nettype wire

// File: rtl/core/trimmed_mean_drop_extremes.sv
// Trimmed mean of a sample set with the largest and smallest samples dropped.
// Samples are taken one per cycle while a set runs; the sample flagged last
// closes the set and starts the closing sequence (numerator, a shared restoring
// divider giving one quotient bit per cycle, then sign and saturation), during
// which input ready is low. The numerator is NUMW = max(sample bits + count bits,
// 17) + 1 bits wide; a short or overflowed set skips the divider. Ready also stays
// low while a finished result waits for a full output register. The result sits
// in an output register, so a new set can start while it waits to be taken.
// Register writes take effect at the next set start.
`default_nettype none

module trimmed_mean_drop_extremes #(
  parameter int unsigned MAX_SAMPLES  = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire tmde_pkg::tmde_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output tmde_pkg::tmde_out_t                    out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [tmde_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned IN_W = (SAMPLE_WIDTH < tmde_pkg::SAMPLE_W) ? SAMPLE_WIDTH
                                                                     : tmde_pkg::SAMPLE_W;
  localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = IN_W + CNTW;
  localparam int unsigned NUMW = ((SUMW > 17) ? SUMW : 17) + 1;

  logic [tmde_pkg::CFG_W-1:0]    range_low_q, range_high_q;
  logic                          xfer, busy, done, slot_free;
  logic [SUMW-1:0]               sum;
  logic [tmde_pkg::SAMPLE_W-1:0] largest, smallest;
  logic [CNTW-1:0]               count;
  logic [tmde_pkg::STATUS_W-1:0] status;
  tmde_pkg::tmde_out_t           result, out_q;
  logic                          out_valid_q;

  assign in_ready_o = !busy;
  assign xfer       = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= tmde_pkg::RANGE_LOW_RST;
      range_high_q <= tmde_pkg::RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmde_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        tmde_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tmde_accum #(
    .IN_W        (IN_W),
    .CNTW        (CNTW),
    .SUMW        (SUMW),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (xfer),
    .item_i       (in_data_i),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .sum_o        (sum),
    .largest_o    (largest),
    .smallest_o   (smallest),
    .count_o      (count),
    .status_o     (status)
  );

  tmde_div #(
    .CNTW (CNTW),
    .SUMW (SUMW),
    .NUMW (NUMW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (xfer && in_data_i.last),
    .sum_i       (sum),
    .largest_i   (largest),
    .smallest_i  (smallest),
    .count_i     (count),
    .status_i    (status),
    .slot_free_i (slot_free),
    .busy_o      (busy),
    .done_o      (done),
    .result_o    (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: bench/trimmed_mean_drop_extremes_test.sv
// self-checking bench for the trimmed mean block: directed sets, then random sets, under stalls until the last run
`timescale 1ns / 100ps

module trimmed_mean_drop_extremes_test;

  localparam int unsigned SET_LIMIT = 256;
  localparam int unsigned DRAIN_CYCLES = 40;

  // expected means of closed sets, worked out from a private copy of the block state
  class mean_scoreboard;
    logic [tmde_pkg::CFG_W-1:0]    range_lo;
    logic [tmde_pkg::CFG_W-1:0]    range_hi;
    logic [23:0]                   sum_acc;
    logic [tmde_pkg::SAMPLE_W-1:0] top_seen;
    logic [tmde_pkg::SAMPLE_W-1:0] bottom_seen;
    int unsigned                   set_count;
    bit                            set_overflow;
    tmde_pkg::tmde_out_t           pending_means[$];
    int                            errors;
    int                            n_ok;
    int                            n_short;
    int                            n_overflow;
    int                            n_negative;

    function new();
      range_lo     = tmde_pkg::RANGE_LOW_RST;
      range_hi     = tmde_pkg::RANGE_HIGH_RST;
      errors       = 0;
      n_ok         = 0;
      n_short      = 0;
      n_overflow   = 0;
      n_negative   = 0;
      clear_set();
    endfunction

    function void clear_set();
      sum_acc      = '0;
      top_seen     = range_lo;
      bottom_seen  = range_hi;
      set_count    = 0;
      set_overflow = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [tmde_pkg::CFG_W-1:0] value);
      if (idx == tmde_pkg::REG_RANGE_LOW) range_lo = value;
      else range_hi = value;
    endfunction

    function void note_input(tmde_pkg::tmde_in_t item);
      tmde_pkg::tmde_out_t           res;
      logic [tmde_pkg::SAMPLE_W-1:0] s;
      longint                        num;
      longint                        den;
      longint                        m;
      s = item.sample;
      // trackers reload from the registers at the start of a set
      if (set_count == 0 && !set_overflow) begin
        top_seen    = range_lo;
        bottom_seen = range_hi;
      end
      if (set_count >= SET_LIMIT) begin
        set_overflow = 1'b1;
      end else begin
        sum_acc = sum_acc + s;
        if (s > top_seen) top_seen = s;
        if (s < bottom_seen) bottom_seen = s;
        set_count++;
      end
      if (!item.last) return;
      m = 0;
      if (set_overflow) begin
        res.status = tmde_pkg::STATUS_OVERFLOW;
        n_overflow++;
      end else if (set_count < 3) begin
        res.status = tmde_pkg::STATUS_SHORT;
        n_short++;
      end else begin
        res.status = tmde_pkg::STATUS_OK;
        num = longint'(sum_acc) - longint'(top_seen) - longint'(bottom_seen);
        den = longint'(set_count) - 2;
        m = num / den;
        if (m > 131071) m = 131071;
        if (m < -131072) m = -131072;
        if (m < 0) n_negative++;
        n_ok++;
      end
      res.mean = m[tmde_pkg::MEAN_W-1:0];
      pending_means.push_back(res);
      clear_set();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(tmde_pkg::tmde_out_t got);
      tmde_pkg::tmde_out_t want;
      if (pending_means.size() == 0) begin
        report($sformatf("result mean=%0d status=%0d with no set pending",
                         $signed(got.mean), got.status));
        return;
      end
      want = pending_means.pop_front();
      if (got.mean !== want.mean)
        report($sformatf("mean %0d, expected %0d", $signed(got.mean), $signed(want.mean)));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask

    task check_drained();
      if (pending_means.size() != 0)
        report($sformatf("%0d results never arrived", pending_means.size()));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  tmde_pkg::tmde_in_t         in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  tmde_pkg::tmde_out_t        out_data;
  logic                       cfg_we = 1'b0;
  logic                       cfg_idx = tmde_pkg::REG_RANGE_LOW;
  logic [tmde_pkg::CFG_W-1:0] cfg_wdata = '0;
  bit                         quiet = 1'b0;
  int                         n_items = 0;

  mean_scoreboard sb = new();

  trimmed_mean_drop_extremes #(
    .MAX_SAMPLES (SET_LIMIT),
    .SAMPLE_WIDTH(tmde_pkg::SAMPLE_W)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls in random bursts, steady ready once the run goes quiet
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) out_ready <= 1'b0;
      else out_ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task send_item(logic [tmde_pkg::SAMPLE_W-1:0] sample, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.sample <= sample;
    in_data.last   <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input('{sample: sample, last: last});
    n_items++;
  endtask

  task send_list(logic [tmde_pkg::SAMPLE_W-1:0] vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [tmde_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sb.range_lo + tmde_pkg::SAMPLE_W'($urandom_range(0, 3)) - 16'd1;
      3: return sb.range_hi + tmde_pkg::SAMPLE_W'($urandom_range(0, 3)) - 16'd1;
      default: return tmde_pkg::SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task send_set(int n);
    for (int i = 0; i < n; i++) send_item(pick_sample(), i == n - 1);
  endtask

  task random_sets(int budget);
    int start;
    start = n_items;
    while (n_items - start < budget) begin
      if ($urandom_range(0, 9) == 0) send_set($urandom_range(1, 2));
      else send_set($urandom_range(3, 12));
    end
  endtask

  // block is idle once the result of every closed set has been taken, then a drain wait follows
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_ranges(logic [tmde_pkg::CFG_W-1:0] lo, logic [tmde_pkg::CFG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= tmde_pkg::REG_RANGE_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= tmde_pkg::REG_RANGE_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(tmde_pkg::REG_RANGE_LOW, lo);
    sb.write_reg(tmde_pkg::REG_RANGE_HIGH, hi);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ranges: short sets, full-scale samples, upper tracker never passed
    send_list('{16'd0});
    send_list('{16'hFFFF, 16'hFFFF});
    send_list('{16'd0, 16'hFFFF, 16'd40960});
    send_list('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_list('{16'd4096, 16'd4096, 16'd4096, 16'd4096});
    wait_idle();

    // inverted ranges: neither tracker is passed, numerator goes negative for the all-zero set
    write_ranges(16'hFFFF, 16'd0);
    send_list('{16'd0, 16'd0, 16'd0});
    send_list('{16'h8000, 16'h1234, 16'hFFFF});
    wait_idle();
    write_ranges(16'd0, 16'hFFFF);
    send_list('{16'd7, 16'd7, 16'd7});
    wait_idle();

    write_ranges(tmde_pkg::CFG_W'($urandom_range(0, 65535)),
                 tmde_pkg::CFG_W'($urandom_range(0, 65535)));
    random_sets(40);
    wait_idle();

    // normal sets, an overflowing set, then normal sets to see the clear
    write_ranges(16'd0, 16'hFFFF);
    random_sets(20);
    send_set(SET_LIMIT + 1 + $urandom_range(0, 4));
    random_sets(20);
    wait_idle();

    quiet = 1'b1;
    write_ranges(tmde_pkg::RANGE_LOW_RST, tmde_pkg::RANGE_HIGH_RST);
    random_sets(40);
    wait_idle();

    sb.check_drained();
    $display("%0d samples in: %0d means, %0d short sets, %0d overflowed sets, %0d negative",
             n_items, sb.n_ok, sb.n_short, sb.n_overflow, sb.n_negative);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tmde_pkg.sv
rtl/core/tmde_accum.sv
rtl/core/tmde_div.sv
rtl/core/trimmed_mean_drop_extremes.sv
bench/trimmed_mean_drop_extremes_test.sv
